// File: hdl/cdfs_pkg.sv
// Shared types and constants for the change-detect frame sender.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cdfs_pkg;

  // Command codes of an input beat
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Send reason codes
  localparam logic [1:0] REASON_NONE    = 2'd0;
  localparam logic [1:0] REASON_CHANGED = 2'd1;
  localparam logic [1:0] REASON_REFRESH = 2'd2;

  // Refresh period after reset
  localparam logic [7:0] REFRESH_RESET = 8'd5;

  // Masked write request into the frame store
  typedef struct packed {
    logic        en;
    logic [2:0]  index;
    logic [63:0] data;
    logic [7:0]  mask;
  } frame_wr_t;

endpackage

// File: hdl/change_detect_frame_sender.sv
// Change-detect frame sender: one input register, one result register.
// An accepted beat passes the input register, then the result register, which shows its result.
// Throughput: one beat per cycle; a stalled result holds the input register
// and the input side stalls only while both registers are occupied.
// Reset (rst, synchronous): frames zero, sent copies every byte 0x01,
// idle counters and scan position zero, refresh period 5.
`timescale 1ns / 1ps

module change_detect_frame_sender
  import cdfs_pkg::*;
#(
  parameter int NUM_FRAMES  = 8,
  parameter int FRAME_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [2:0]  frame_index,
  input  logic [63:0] write_data,
  input  logic [7:0]  byte_mask,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        send_valid,
  output logic [2:0]  send_frame,
  output logic [63:0] send_payload,
  output logic [1:0]  send_reason
);

  localparam int FRAME_W = 8 * FRAME_BYTES;
  localparam int POS_W   = $clog2(NUM_FRAMES);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(NUM_FRAMES - 1);

  // Configuration register
  logic [7:0] refresh_period;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_period <= REFRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      refresh_period <= cfg_data;
    end
  end

  // Input register
  logic        i_valid;
  logic        i_cmd;
  logic [2:0]  i_index;
  logic [63:0] i_data;
  logic [7:0]  i_mask;
  logic        advance;

  assign advance  = i_valid && (!out_valid || !out_stall);
  assign in_stall = i_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      i_valid <= 1'b1;
    end else if (advance) begin
      i_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      i_cmd   <= cmd;
      i_index <= frame_index;
      i_data  <= write_data;
      i_mask  <= byte_mask;
    end
  end

  // Frame store
  frame_wr_t          wr;
  logic [POS_W-1:0]   scan_pos;
  logic [FRAME_W-1:0] cur_frame;

  assign wr.en    = advance && (i_cmd == CMD_WRITE);
  assign wr.index = i_index;
  assign wr.data  = i_data;
  assign wr.mask  = i_mask;

  cdfs_frame_store #(
    .NUM_FRAMES  (NUM_FRAMES),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_pos  (scan_pos),
    .rd_data (cur_frame)
  );

  // Scan-side state
  logic [FRAME_W-1:0] sent_copy [NUM_FRAMES];
  logic [7:0]         idle_cnt  [NUM_FRAMES];

  // Tick decision for the frame under the scan position
  logic       tick;
  logic       changed;
  logic [7:0] cnt_inc;
  logic       refresh_hit;

  assign tick        = advance && (i_cmd == CMD_TICK);
  assign changed     = (cur_frame != sent_copy[scan_pos]);
  assign cnt_inc     = idle_cnt[scan_pos] + 8'd1;
  assign refresh_hit = !changed && (cnt_inc == refresh_period);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pos <= '0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        sent_copy[i] <= {FRAME_BYTES{8'h01}};
        idle_cnt[i]  <= '0;
      end
    end else if (tick) begin
      scan_pos <= (scan_pos == POS_LAST) ? '0 : scan_pos + POS_W'(1);
      if (changed) begin
        sent_copy[scan_pos] <= cur_frame;
        idle_cnt[scan_pos]  <= '0;
      end else if (refresh_hit) begin
        idle_cnt[scan_pos]  <= '0;
      end else begin
        idle_cnt[scan_pos]  <= cnt_inc;
      end
    end
  end

  // Result register
  logic sending;

  assign sending = (i_cmd == CMD_TICK) && (changed || refresh_hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      send_valid   <= sending;
      send_frame   <= sending ? 3'(scan_pos) : 3'd0;
      send_payload <= sending ? 64'(cur_frame) : 64'd0;
      if (!sending) begin
        send_reason <= REASON_NONE;
      end else if (changed) begin
        send_reason <= REASON_CHANGED;
      end else begin
        send_reason <= REASON_REFRESH;
      end
    end
  end

endmodule

// File: hdl/cdfs_frame_store.sv
// Transmit frame store: byte-masked writes, one read port at the scan position.
// Depends on cdfs_pkg (frame_wr_t).
`timescale 1ns / 1ps

module cdfs_frame_store
  import cdfs_pkg::*;
#(
  parameter int NUM_FRAMES  = 8,
  parameter int FRAME_BYTES = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  frame_wr_t                         wr,
  input  logic [$clog2(NUM_FRAMES)-1:0]     rd_pos,
  output logic [8*FRAME_BYTES-1:0]          rd_data
);

  localparam int FRAME_W = 8 * FRAME_BYTES;

  logic [FRAME_W-1:0] frames [NUM_FRAMES];

  // Per-entry, per-byte write enables; indexes beyond the store are dropped
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (rst) begin
        frames[i] <= '0;
      end else if (wr.en && (32'(wr.index) == i)) begin
        for (int b = 0; b < FRAME_BYTES; b++) begin
          if (wr.mask[b]) begin
            frames[i][8*b +: 8] <= wr.data[8*b +: 8];
          end
        end
      end
    end
  end

  // Read at the scan position
  assign rd_data = frames[rd_pos];

endmodule

// File: hdl/cdfs_checker.sv
// Port-level checks for the change-detect frame sender, bound to the top level.
// Depends on cdfs_pkg (reason codes) and change_detect_frame_sender.
`timescale 1ns / 1ps

module cdfs_checker
  import cdfs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        send_valid,
  input logic [2:0]  send_frame,
  input logic [63:0] send_payload,
  input logic [1:0]  send_reason
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(send_valid) && $stable(send_frame)
      && $stable(send_payload) && $stable(send_reason))
    else $error("result beat changed while stalled");

  // Nothing sent means an all-zero result
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !send_valid |-> send_frame == 3'd0 && send_payload == 64'd0
      && send_reason == REASON_NONE)
    else $error("unsent result carries data");

  // A send always carries a reason, and only a known one
  a_reason: assert property (@(posedge clk) disable iff (rst)
    out_valid && send_valid |-> send_reason == REASON_CHANGED
      || send_reason == REASON_REFRESH)
    else $error("send without valid reason");

  // Input side stalls only under output backpressure
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output flows");

endmodule

bind change_detect_frame_sender cdfs_checker u_cdfs_checker (.*);
